@@ hdl/vsbc_pkg.sv @@
package vsbc_pkg;

  // register indexes, taken from paddr[3:2]
  localparam logic [1:0] REG_SPEED_LIMIT = 2'd0;
  localparam logic [1:0] REG_OFFSET_X    = 2'd1;
  localparam logic [1:0] REG_OFFSET_Y    = 2'd2;

  localparam logic [12:0] SPEED_LIMIT_RST = 13'd1229;

  // boost countdown values
  localparam logic [5:0] LEFT_SHORT = 6'd8;
  localparam logic [5:0] LEFT_LONG  = 6'd20;
  localparam logic [5:0] LEFT_IDLE  = 6'h3f;

  // phase step: compensation from step 6, wrap after step 7
  localparam logic [3:0] PHASE_COMP_FIRST = 4'd6;
  localparam logic [3:0] PHASE_LAST       = 4'd7;

  // floor(y / 5) == (y * RECIP5) >> RECIP5_SHIFT for y < 2^18
  localparam logic [15:0] RECIP5       = 16'd52429;
  localparam int          RECIP5_SHIFT = 18;

  typedef struct packed {
    logic        [12:0] limit;
    logic signed [15:0] offset;
    logic        [14:0] mag27;   // floor(2.7 * limit), the 1.35 scaled boost
    logic signed [15:0] lvl_up;  // scaled level for an upward jump, saturated
    logic signed [15:0] lvl_dn;  // scaled level for a downward jump, saturated
  } axis_cfg_t;

endpackage

@@ hdl/vsbc_cfg.sv @@
module vsbc_cfg #(
  parameter int FRAC_BITS = 12
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output vsbc_pkg::axis_cfg_t axis_x_o,
  output vsbc_pkg::axis_cfg_t axis_y_o
);
  import vsbc_pkg::*;

  localparam int SW = (FRAC_BITS + 2 > 15) ? FRAC_BITS + 2 : 15;
  localparam int PW = 14 + SW - 1;
  localparam int QW = PW - FRAC_BITS;
  localparam logic signed [SW-1:0] One = {{(SW-1){1'b0}}, 1'b1} << FRAC_BITS;

  logic        [12:0] limit_q;
  logic signed [15:0] off_q [2];

  logic               wr_en;
  logic        [13:0] lim2;
  logic        [17:0] x27;
  logic        [32:0] prod27;
  logic        [14:0] mag27_q;
  logic signed [15:0] lvl_up_q [2];
  logic signed [15:0] lvl_dn_q [2];

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q  <= SPEED_LIMIT_RST;
      off_q[0] <= '0;
      off_q[1] <= '0;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_SPEED_LIMIT: limit_q  <= pwdata[12:0];
        REG_OFFSET_X:    off_q[0] <= pwdata[15:0];
        REG_OFFSET_Y:    off_q[1] <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_SPEED_LIMIT: prdata = {19'd0, limit_q};
      REG_OFFSET_X:    prdata = {{16{off_q[0][15]}}, off_q[0]};
      REG_OFFSET_Y:    prdata = {{16{off_q[1][15]}}, off_q[1]};
      default:         prdata = '0;
    endcase
  end

  // derived boost levels, registered; they follow a register write in the next cycle
  assign lim2   = {limit_q, 1'b0};
  assign x27    = (18'(limit_q) << 4) + (18'(limit_q) << 3) + (18'(limit_q) << 1)
                + 18'(limit_q);
  assign prod27 = 33'(x27[17:1]) * 33'(RECIP5);

  always_ff @(posedge clk_i) begin
    mag27_q <= prod27[RECIP5_SHIFT +: 15];
  end

  for (genvar a = 0; a < 2; a++) begin : g_axis
    logic        [16:0]   abs_off;
    logic        [18:0]   coef5;
    logic        [12:0]   coef;
    logic signed [SW-1:0] fac;
    logic        [SW-2:0] abs_fac;
    logic        [PW-1:0] prod;
    logic        [QW:0]   qx;
    logic signed [15:0]   pos_v;
    logic signed [15:0]   neg_v;

    always_comb begin
      abs_off = off_q[a][15] ? 17'(-{off_q[a][15], off_q[a]}) : {1'b0, off_q[a]};
      coef5   = ({2'b0, abs_off} << 2) + {2'b0, abs_off};
      coef    = (coef5 >= 19'(limit_q)) ? limit_q : coef5[12:0];
      fac     = One - $signed({{(SW-13){1'b0}}, coef});
      abs_fac = fac[SW-1] ? (SW-1)'(-fac) : fac[SW-2:0];
      prod    = PW'(lim2) * PW'(abs_fac);
      qx      = {1'b0, prod[PW-1:FRAC_BITS]};
      pos_v   = (qx > (QW+1)'(32767)) ? 16'sh7fff : $signed(qx[15:0]);
      neg_v   = (qx > (QW+1)'(32768)) ? 16'sh8000 : $signed(16'(-qx[15:0]));
    end

    // a negative factor flips the sign of the level
    always_ff @(posedge clk_i) begin
      lvl_up_q[a] <= fac[SW-1] ? neg_v : pos_v;
      lvl_dn_q[a] <= fac[SW-1] ? pos_v : neg_v;
    end
  end

  assign axis_x_o = '{limit: limit_q, offset: off_q[0], mag27: mag27_q,
                      lvl_up: lvl_up_q[0], lvl_dn: lvl_dn_q[0]};
  assign axis_y_o = '{limit: limit_q, offset: off_q[1], mag27: mag27_q,
                      lvl_up: lvl_up_q[1], lvl_dn: lvl_dn_q[1]};

endmodule

@@ hdl/vsbc_axis.sv @@
module vsbc_axis (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  logic                comp_i,
  input  logic signed [15:0]  cmd_i,
  input  vsbc_pkg::axis_cfg_t cfg_i,
  output logic signed [15:0]  out_o,
  output logic                boost_o
);
  import vsbc_pkg::*;

  logic signed [15:0] prev_q, prev_d;
  logic               on_q, on_d;
  logic signed [15:0] level_q, level_d;
  logic        [5:0]  left_q, left_d;

  logic signed [16:0] cmd_w, prev_w, diff, sum;
  logic        [16:0] abs_prev, jump_mag;
  logic        [18:0] d5, l4, l6;
  logic signed [15:0] pos2, neg2, p27, n27, new_level, pre_out;
  logic               try_boost, hit, short_jump, up, same_sign;
  logic               on_a;
  logic signed [15:0] level_a;
  logic        [5:0]  left_a;

  always_comb begin
    cmd_w    = {cmd_i[15], cmd_i};
    prev_w   = {prev_q[15], prev_q};
    abs_prev = prev_q[15] ? 17'(-prev_w) : prev_w;
    diff     = cmd_w - prev_w;
    jump_mag = diff[16] ? 17'(-diff) : diff;
    d5       = ({2'b0, jump_mag} << 2) + {2'b0, jump_mag};
    l4       = 19'(cfg_i.limit) << 2;
    l6       = (19'(cfg_i.limit) << 2) + (19'(cfg_i.limit) << 1);

    // no new boost while one runs or while the output magnitude is twice the limit
    try_boost  = !on_q && (abs_prev != {3'b0, cfg_i.limit, 1'b0});
    hit        = d5 > l4;
    short_jump = d5 < l6;
    up         = prev_q < cmd_i;
    same_sign  = ((cmd_i > 0) && (cfg_i.offset > 0)) || ((cmd_i < 0) && (cfg_i.offset < 0));

    pos2 = $signed({2'b0, cfg_i.limit, 1'b0});
    neg2 = -pos2;
    p27  = $signed({1'b0, cfg_i.mag27});
    n27  = -p27;

    priority if (short_jump) new_level = up ? pos2 : neg2;
    else if (same_sign)      new_level = up ? p27 : n27;
    else                     new_level = up ? cfg_i.lvl_up : cfg_i.lvl_dn;

    if (try_boost && hit) begin
      on_a    = 1'b1;
      level_a = new_level;
      left_a  = short_jump ? LEFT_SHORT : LEFT_LONG;
    end else begin
      on_a    = on_q;
      level_a = level_q;
      left_a  = left_q;
    end

    on_d    = on_a;
    level_d = level_a;
    left_d  = left_a;
    if (on_a) begin
      if (left_a == '0) begin
        on_d    = 1'b0;
        level_d = '0;
        left_d  = LEFT_IDLE;
      end else begin
        left_d  = left_a - 6'd1;
      end
    end

    pre_out = on_d ? level_d : cmd_i;
    sum     = {pre_out[15], pre_out} + {cfg_i.offset[15], cfg_i.offset};
    if (comp_i && !on_d) begin
      prev_d = (sum[16] != sum[15]) ? (sum[16] ? 16'sh8000 : 16'sh7fff) : sum[15:0];
    end else begin
      prev_d = pre_out;
    end
  end

  // prev_q and on_q double as the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= '0;
      on_q    <= 1'b0;
      level_q <= '0;
      left_q  <= LEFT_IDLE;
    end else if (adv_i) begin
      prev_q  <= prev_d;
      on_q    <= on_d;
      level_q <= level_d;
      left_q  <= left_d;
    end
  end

  assign out_o   = prev_q;
  assign boost_o = on_q;

endmodule

@@ hdl/velocity_step_boost_compensator_unit.sv @@
// Velocity step boost compensator.
// Input channel: in_valid_i / in_stall_o with vel_x_i, vel_y_i (signed Q3.12).
// A beat is taken at a clock edge with valid high and stall low.
// Output channel: out_valid_o / out_stall_i with shaped_x_o, shaped_y_o and
// boosting_x_o, boosting_y_o; one result beat for every input beat, in order.
// The beat lands in the input register, and the per-axis boost/compensation
// update then takes it into the result register.
// Throughput is one beat per cycle unless the receiver stalls; the state of
// previous output and boost feeds back, so each beat sees the one before it.
// When the receiver stalls, the result holds and the input register keeps one
// further beat; in_stall_o rises only while both registers are full.
// Reset clears the phase counter, previous outputs and boost state, and loads
// the register defaults (limit 1229, offsets 0). The APB port (pready always
// high) holds speed_limit, offset_x, offset_y at 0x0, 0x4, 0x8; the derived
// boost levels follow a register write in the next cycle.
module velocity_step_boost_compensator_unit #(
  parameter int FRAC_BITS = 12
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] vel_x_i,
  input  logic signed [15:0] vel_y_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] shaped_x_o,
  output logic signed [15:0] shaped_y_o,
  output logic               boosting_x_o,
  output logic               boosting_y_o
);
  import vsbc_pkg::*;

  axis_cfg_t          cfg_x, cfg_y;
  logic               in_vld_q, out_vld_q;
  logic signed [15:0] vel_x_q, vel_y_q;
  logic        [2:0]  phase_q;
  logic        [3:0]  phase_nx;
  logic               adv, take_in, comp;

  vsbc_cfg #(
    .FRAC_BITS(FRAC_BITS)
  ) u_cfg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .axis_x_o (cfg_x),
    .axis_y_o (cfg_y)
  );

  assign adv        = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !adv;
  assign take_in    = in_valid_i && !in_stall_o;

  assign phase_nx = {1'b0, phase_q} + 4'd1;
  assign comp     = phase_nx >= PHASE_COMP_FIRST;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      phase_q   <= '0;
    end else begin
      if (take_in) begin
        in_vld_q <= 1'b1;
      end else if (adv) begin
        in_vld_q <= 1'b0;
      end
      if (adv) begin
        out_vld_q <= 1'b1;
        phase_q   <= (phase_nx >= PHASE_LAST) ? 3'd0 : phase_nx[2:0];
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_in) begin
      vel_x_q <= vel_x_i;
      vel_y_q <= vel_y_i;
    end
  end

  vsbc_axis u_axis_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .comp_i  (comp),
    .cmd_i   (vel_x_q),
    .cfg_i   (cfg_x),
    .out_o   (shaped_x_o),
    .boost_o (boosting_x_o)
  );

  vsbc_axis u_axis_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .comp_i  (comp),
    .cmd_i   (vel_y_q),
    .cfg_i   (cfg_y),
    .out_o   (shaped_y_o),
    .boost_o (boosting_y_o)
  );

  assign out_valid_o = out_vld_q;

endmodule

@@ test/tb_velocity_step_boost_compensator_unit.sv @@
`timescale 1ns / 100ps

module tb_velocity_step_boost_compensator_unit;
  import vsbc_pkg::*;

  localparam int FRAC_BITS   = 12;
  localparam int HOLD_LEN    = 60;
  localparam int QUIET_LIMIT = 1000;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 48;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
  } vel_t;

  typedef struct packed {
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    logic               bx;
    logic               by;
  } shaped_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [3:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid = 1'b0;
  logic               in_stall_o;
  logic signed [15:0] vel_x = '0;
  logic signed [15:0] vel_y = '0;
  logic               out_valid_o;
  logic               out_stall = 1'b0;
  logic signed [15:0] shaped_x_o;
  logic signed [15:0] shaped_y_o;
  logic               boosting_x_o;
  logic               boosting_y_o;

  velocity_step_boost_compensator_unit #(.FRAC_BITS(FRAC_BITS)) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall_o),
    .vel_x_i      (vel_x),
    .vel_y_i      (vel_y),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall),
    .shaped_x_o   (shaped_x_o),
    .shaped_y_o   (shaped_y_o),
    .boosting_x_o (boosting_x_o),
    .boosting_y_o (boosting_y_o)
  );

  // register mirror and shaper state, index 0 = x, 1 = y
  int limit_m = SPEED_LIMIT_RST;
  int off_m[2] = '{0, 0};
  int phase_s = 0;
  int prev_s[2] = '{0, 0};
  bit on_s[2] = '{1'b0, 1'b0};
  int lvl_s[2] = '{0, 0};
  int left_s[2] = '{-1, -1};

  vel_t    vel_q[$];
  shaped_t shaped_q[$];

  int  send_idle_pct = 11;
  int  recv_stall_pct = 58;
  int  hold_reqs = 0;
  int  hold_done = 0;
  int  hold_left = 0;
  bit  in_took = 1'b0;
  int  quiet = 0;
  int  errors = 0;
  int  cmds_sent = 0;
  int  results_seen = 0;
  int  boosted_seen = 0;
  int  settings_used = 0;
  int  last_x = 0;
  int  last_y = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint abs_l(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic int sat16(input longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return int'(v);
  endfunction

  // boost detection, countdown and hold for one axis; returns the axis value
  function automatic int shape_axis(input int a, input int cmd);
    longint lim, d, lv, coef, unity;
    int res;
    lim = limit_m;
    unity = longint'(1) << FRAC_BITS;
    res = cmd;
    if (!on_s[a] && abs_l(prev_s[a]) != 2 * lim) begin
      d = abs_l(longint'(cmd) - prev_s[a]);
      if (5 * d > 4 * lim) begin
        lv = (prev_s[a] < cmd) ? 2 * lim : -2 * lim;
        on_s[a] = 1'b1;
        if (5 * d < 6 * lim) begin
          left_s[a] = LEFT_SHORT;
        end else begin
          if ((cmd > 0 && off_m[a] > 0) || (cmd < 0 && off_m[a] < 0)) begin
            lv = (lv * 27) / 20;
          end else begin
            coef = 5 * abs_l(off_m[a]);
            if (coef >= lim) coef = lim;
            lv = (lv * (unity - coef)) / unity;
          end
          left_s[a] = LEFT_LONG;
        end
        lvl_s[a] = sat16(lv);
      end
    end
    if (on_s[a]) begin
      left_s[a] = left_s[a] - 1;
      if (left_s[a] < 0) begin
        on_s[a] = 1'b0;
        lvl_s[a] = 0;
        left_s[a] = -1;
      end
    end
    if (on_s[a]) res = lvl_s[a];
    return res;
  endfunction

  task automatic predict_shape(input logic signed [15:0] vx, input logic signed [15:0] vy);
    shaped_t e;
    int p, ox, oy;
    p = (phase_s & 7) + 1;
    ox = shape_axis(0, vx);
    oy = shape_axis(1, vy);
    if (p >= PHASE_COMP_FIRST) begin
      if (!on_s[0]) ox = sat16(longint'(ox) + off_m[0]);
      if (!on_s[1]) oy = sat16(longint'(oy) + off_m[1]);
    end
    phase_s = (p >= PHASE_LAST) ? 0 : p;
    prev_s[0] = ox;
    prev_s[1] = oy;
    e.sx = 16'(ox);
    e.sy = 16'(oy);
    e.bx = on_s[0];
    e.by = on_s[1];
    shaped_q.push_back(e);
  endtask

  task automatic report_mismatch(input string msg);
    errors++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want)
      report_mismatch($sformatf("%s got %0d want %0d (result %0d)", name, got, want,
                                results_seen));
  endtask

  // sender: a beat stays on the bus until taken
  always @(negedge clk_i) begin : drive_cmd
    vel_t beat;
    if (rst_ni && (!in_valid || in_took)) begin
      if (vel_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        beat = vel_q.pop_front();
        in_valid <= 1'b1;
        vel_x <= beat.x;
        vel_y <= beat.y;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls plus a long hold-off on request
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_reqs != hold_done) begin
      hold_done <= hold_done + 1;
      hold_left <= HOLD_LEN;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin : watch_beats
    shaped_t want;
    in_took <= rst_ni && in_valid && !in_stall_o;
    if (rst_ni && out_valid_o && !out_stall) begin
      if (shaped_q.size() == 0) begin
        report_mismatch("result beat with no command pending");
      end else begin
        want = shaped_q.pop_front();
        check_field("shaped_x", shaped_x_o, want.sx);
        check_field("shaped_y", shaped_y_o, want.sy);
        check_field("boosting_x", boosting_x_o, want.bx);
        check_field("boosting_y", boosting_y_o, want.by);
        if (want.bx || want.by) boosted_seen++;
      end
      results_seen++;
    end
    if (rst_ni && in_valid && !in_stall_o) begin
      predict_shape(vel_x, vel_y);
      cmds_sent++;
    end
  end

  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || psel || (in_valid && !in_stall_o) || (out_valid_o && !out_stall))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("timeout: no beat for %0d cycles", QUIET_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    case (idx)
      REG_SPEED_LIMIT: limit_m = int'(val[12:0]);
      REG_OFFSET_X:    off_m[0] = int'($signed(val[15:0]));
      REG_OFFSET_Y:    off_m[1] = int'($signed(val[15:0]));
      default: ;
    endcase
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // sender pauses until every result is back, then the pipe settles
  task automatic wait_drained();
    while (vel_q.size() != 0 || in_valid || shaped_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_regs(input int lim, input int ox, input int oy);
    wait_drained();
    apb_write(REG_SPEED_LIMIT, 32'(lim));
    apb_write(REG_OFFSET_X, 32'(ox));
    apb_write(REG_OFFSET_Y, 32'(oy));
    repeat (3) @(posedge clk_i);
    settings_used++;
  endtask

  task automatic push_cmd(input int x, input int y);
    vel_t v;
    v.x = 16'(x);
    v.y = 16'(y);
    vel_q.push_back(v);
    last_x = x;
    last_y = y;
  endtask

  // often steps around the last command so boosts of both lengths happen
  function automatic int next_cmd(input int last, input int lim);
    int k;
    k = $urandom_range(99);
    if (k < 35) return int'($urandom_range(65535)) - 32768;
    if (k < 80) return sat16(longint'(last) + int'($urandom_range(6 * lim + 2)) - (3 * lim + 1));
    case ($urandom_range(4))
      0: return 32767;
      1: return -32768;
      2: return 0;
      3: return sat16(2 * lim);
      default: return sat16(-2 * lim);
    endcase
  endfunction

  initial begin : stimulus
    int lim, ox, oy;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // reset settings: short boost, its full countdown, then a jump from 2L
    push_cmd(0, 0);
    repeat (9) push_cmd(1200, -1200);
    push_cmd(2000, -2000);
    push_cmd(2458, -2458);
    push_cmd(0, 0);
    // long boost with zero offset
    push_cmd(32767, -32768);
    write_regs(8191, 32767, -32768);
    // these arrive while the long boost counts down, so they start no new boost
    push_cmd(-1, 1);
    push_cmd(32767, -32768);
    push_cmd(-32768, 32767);
    push_cmd(0, 0);

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin lim = 8191; ox = -32768; oy = 32767; end
        1: begin lim = 0; ox = 32767; oy = -32768; end
        3: begin
          lim = SPEED_LIMIT_RST;
          ox = int'($urandom_range(800)) - 400;
          oy = int'($urandom_range(800)) - 400;
        end
        4: begin lim = 8191; ox = 0; oy = int'($urandom_range(65535)) - 32768; end
        6: begin
          lim = $urandom_range(2000);
          ox = int'($urandom_range(600)) - 300;
          oy = int'($urandom_range(600)) - 300;
        end
        default: begin
          lim = $urandom_range(8191);
          ox = int'($urandom_range(65535)) - 32768;
          oy = int'($urandom_range(65535)) - 32768;
        end
      endcase
      write_regs(lim, ox, oy);
      if (ph < 3) begin
        send_idle_pct = 11;
        recv_stall_pct = 58;
      end else if (ph < 6) begin
        send_idle_pct = 58;
        recv_stall_pct = 11;
      end else begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      for (int i = 0; i < PHASE_ITEMS; i++)
        push_cmd(next_cmd(last_x, lim), next_cmd(last_y, lim));
      // long receiver hold-off while commands keep coming
      if (ph == 1 || ph == 6) hold_reqs++;
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    $display("%0d commands, %0d results checked, %0d with a boosted axis",
             cmds_sent, results_seen, boosted_seen);
    $display("%0d register settings incl. limit 0/8191 and offset extremes", settings_used);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
